### hdl/stuck_pixel_counter_core_macros.svh
// assertion macros shared by the stuck pixel counter modules
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef STUCK_PIXEL_COUNTER_CORE_MACROS_SVH
`define STUCK_PIXEL_COUNTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spc assertion failed");
// condition must never be seen outside reset
`define SPC_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("spc forbidden condition seen");
`else
`define SPC_ASSERT(lbl, clk, rstn, prop)
`define SPC_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### hdl/spc_pkg.sv
// package for the stuck pixel counter: sizes, register codes, fsm states
// and the command/status structs between controller and datapath
// no dependencies
package spc_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int MAX_FRAMES = 64;

  localparam int PIX_W      = 8;
  localparam int PP_W       = 2 * PIX_W;
  localparam int FPC_W      = 17;
  localparam int LIM_W      = 12;
  localparam int MARG_W     = 8;
  localparam int CNT_W      = 17;
  localparam int FU_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FLAT_SHIFT = 8;

  localparam int GREY_MAX_I = 255;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SIZE_W = $clog2(MAX_PIXELS + 1);
  localparam int FS_W   = (FPC_W > SIZE_W) ? FPC_W : SIZE_W;
  localparam int FN_W   = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W  = $clog2(MAX_FRAMES * GREY_MAX_I + 1);
  localparam int SQ_W   = $clog2(MAX_FRAMES * GREY_MAX_I * GREY_MAX_I + 1);
  localparam int NQ_W   = FN_W + SQ_W;
  localparam int SS_W   = 2 * SUM_W;
  localparam int SPR_W  = (NQ_W > SS_W) ? NQ_W : SS_W;
  localparam int LHS_W  = SPR_W + FLAT_SHIFT;
  localparam int LIM2_W = 2 * LIM_W;
  localparam int NN_W   = 2 * FN_W;
  localparam int RHS_W  = LIM2_W + NN_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int NM_W   = FN_W + MARG_W;
  localparam int XW     = (SUM_W > NM_W) ? SUM_W : NM_W;

  localparam logic [PIX_W-1:0] GREY_MAX = PIX_W'(GREY_MAX_I);

  localparam logic [FPC_W-1:0]  FPC_RESET    = FPC_W'(65536);
  localparam logic [LIM_W-1:0]  LIMIT_RESET  = LIM_W'(16);
  localparam logic [MARG_W-1:0] MARGIN_RESET = MARG_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PIXEL_COUNT = 2'd0,
    REG_FLAT_LIMIT_Q4     = 2'd1,
    REG_EXTREME_MARGIN    = 2'd2
  } spc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ACC  = 3'd1,
    ST_MUL1 = 3'd2,
    ST_MUL2 = 3'd3,
    ST_TEST = 3'd4
  } spc_state_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic mul1;
    logic mul2;
    logic test;
    logic emit;
  } spc_cmd_t;

  typedef struct packed {
    logic last_px;
    logic final_px;
  } spc_sts_t;

endpackage

### hdl/spc_ram.sv
// generic single write port ram with registered read
// no dependencies
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/spc_ctrl.sv
// controller fsm for the stuck pixel counter: sequences one pixel request
// through read, accumulate, two multiply steps and the test
// depends on spc_pkg and stuck_pixel_counter_core_macros.svh
`include "stuck_pixel_counter_core_macros.svh"

module spc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  spc_pkg::spc_sts_t sts,
  output spc_pkg::spc_cmd_t cmd,
  output logic              busy
);

  spc_pkg::spc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spc_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = spc_pkg::ST_ACC;
        end
      end
      spc_pkg::ST_ACC:  state_nxt = spc_pkg::ST_MUL1;
      spc_pkg::ST_MUL1: state_nxt = spc_pkg::ST_MUL2;
      spc_pkg::ST_MUL2: state_nxt = spc_pkg::ST_TEST;
      spc_pkg::ST_TEST: state_nxt = spc_pkg::ST_IDLE;
      default:          state_nxt = spc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      spc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      spc_pkg::ST_ACC:  cmd.acc  = 1'b1;
      spc_pkg::ST_MUL1: cmd.mul1 = 1'b1;
      spc_pkg::ST_MUL2: cmd.mul2 = 1'b1;
      spc_pkg::ST_TEST: begin
        cmd.test = 1'b1;
        // result only after the last pixel of a frame flagged final
        cmd.emit = sts.last_px && sts.final_px;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `SPC_ASSERT(a_accept_goes_acc, clk, rst_n, (start && !busy) |=> (state_r == spc_pkg::ST_ACC))
  `SPC_ASSERT(a_test_returns_idle, clk, rst_n, (state_r == spc_pkg::ST_TEST) |=> !busy)
  `SPC_ASSERT(a_one_step, clk, rst_n, $onehot0({cmd.load, cmd.acc, cmd.mul1, cmd.mul2, cmd.test}))

endmodule

### hdl/spc_dp.sv
// datapath for the stuck pixel counter: config registers, per position
// sum and square sum rams, variance and mean test, stuck total and result
// depends on spc_pkg, spc_ram and stuck_pixel_counter_core_macros.svh
`include "stuck_pixel_counter_core_macros.svh"

module spc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  spc_pkg::spc_cmd_t                cmd,
  output spc_pkg::spc_sts_t                sts,
  input  logic [spc_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic                             in_final_frame,
  output logic                             out_valid,
  output logic [spc_pkg::CNT_W-1:0]        out_stuck_count,
  output logic [spc_pkg::FU_W-1:0]         out_frames_used
);

  // configuration
  logic [spc_pkg::FPC_W-1:0]  fpc_r, fpc_nxt;
  logic [spc_pkg::LIM_W-1:0]  lim_r, lim_nxt;
  logic [spc_pkg::MARG_W-1:0] margin_r, margin_nxt;

  // sequence state
  logic [spc_pkg::ADDR_W-1:0] pos_r, pos_nxt;
  logic [spc_pkg::FN_W-1:0]   frame_r, frame_nxt;
  logic [spc_pkg::CNT_W-1:0]  total_r, total_nxt;

  // per request pipeline
  logic [spc_pkg::PIX_W-1:0]  pix_r, pix_nxt;
  logic [spc_pkg::PP_W-1:0]   pp_r, pp_nxt;
  logic                       fin_r, fin_nxt;
  logic                       last_r, last_nxt;
  logic [spc_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [spc_pkg::FN_W-1:0]   n_r, n_nxt;
  logic [spc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [spc_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [spc_pkg::NQ_W-1:0]   nq_r, nq_nxt;
  logic [spc_pkg::SS_W-1:0]   ss_r, ss_nxt;
  logic [spc_pkg::LIM2_W-1:0] lim2_r, lim2_nxt;
  logic [spc_pkg::NN_W-1:0]   nn_r, nn_nxt;
  logic [spc_pkg::NM_W-1:0]   lo_r, lo_nxt;
  logic [spc_pkg::NM_W-1:0]   hi_r, hi_nxt;
  logic [spc_pkg::LHS_W-1:0]  lhs_r, lhs_nxt;
  logic [spc_pkg::RHS_W-1:0]  rhs_r, rhs_nxt;
  logic                       ext_r, ext_nxt;

  // result
  logic                       out_valid_r, out_valid_nxt;
  logic [spc_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [spc_pkg::FU_W-1:0]   out_frames_r, out_frames_nxt;

  // combinational helpers
  logic [spc_pkg::FS_W-1:0]   fpc_ext, fsize, pos_ext, pos_cl;
  logic [spc_pkg::ADDR_W-1:0] rd_addr;
  logic                       last_now;
  logic                       fr_lt_max;
  logic [spc_pkg::SUM_W-1:0]  rd_sum, acc_sum;
  logic [spc_pkg::SQ_W-1:0]   rd_sq, acc_sq;
  logic                       acc_we;
  logic [spc_pkg::SPR_W-1:0]  nq_e, ss_e, spread;
  logic [spc_pkg::MARG_W-1:0] hi_margin;
  logic                       flat, stuck;
  logic [spc_pkg::CNT_W-1:0]  total_inc;

  // effective frame size and clamped position
  always_comb begin
    fpc_ext = spc_pkg::FS_W'(fpc_r);
    if (fpc_ext == '0) begin
      fsize = spc_pkg::FS_W'(1);
    end else if (fpc_ext > spc_pkg::FS_W'(spc_pkg::MAX_PIXELS)) begin
      fsize = spc_pkg::FS_W'(spc_pkg::MAX_PIXELS);
    end else begin
      fsize = fpc_ext;
    end
    pos_ext  = spc_pkg::FS_W'(pos_r);
    pos_cl   = (pos_ext >= fsize) ? fsize - spc_pkg::FS_W'(1) : pos_ext;
    rd_addr  = pos_cl[spc_pkg::ADDR_W-1:0];
    last_now = (pos_cl + spc_pkg::FS_W'(1)) >= fsize;
  end

  assign fr_lt_max = frame_r < spc_pkg::FN_W'(spc_pkg::MAX_FRAMES);

  // first frame overwrites, saturated frames leave the entry alone
  always_comb begin
    if (frame_r == '0) begin
      acc_sum = spc_pkg::SUM_W'(pix_r);
      acc_sq  = spc_pkg::SQ_W'(pp_r);
    end else if (fr_lt_max) begin
      acc_sum = rd_sum + spc_pkg::SUM_W'(pix_r);
      acc_sq  = rd_sq + spc_pkg::SQ_W'(pp_r);
    end else begin
      acc_sum = rd_sum;
      acc_sq  = rd_sq;
    end
    acc_we = cmd.acc && fr_lt_max;
  end

  spc_ram #(
    .WIDTH (spc_pkg::SUM_W),
    .DEPTH (spc_pkg::MAX_PIXELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (addr_r),
    .wdata (acc_sum),
    .re    (cmd.load),
    .raddr (rd_addr),
    .rdata (rd_sum)
  );

  spc_ram #(
    .WIDTH (spc_pkg::SQ_W),
    .DEPTH (spc_pkg::MAX_PIXELS)
  ) u_sq_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (addr_r),
    .wdata (acc_sq),
    .re    (cmd.load),
    .raddr (rd_addr),
    .rdata (rd_sq)
  );

  // variance and mean tests
  always_comb begin
    nq_e      = spc_pkg::SPR_W'(nq_r);
    ss_e      = spc_pkg::SPR_W'(ss_r);
    // negative spread counts as zero variance
    spread    = (nq_e > ss_e) ? nq_e - ss_e : '0;
    hi_margin = spc_pkg::GREY_MAX - margin_r;
    flat      = spc_pkg::CMP_W'(lhs_r) < spc_pkg::CMP_W'(rhs_r);
    stuck     = flat && ext_r && fin_r;
    total_inc = total_r + spc_pkg::CNT_W'(stuck);
  end

  always_comb begin
    fpc_nxt        = fpc_r;
    lim_nxt        = lim_r;
    margin_nxt     = margin_r;
    pos_nxt        = pos_r;
    frame_nxt      = frame_r;
    total_nxt      = total_r;
    pix_nxt        = pix_r;
    pp_nxt         = pp_r;
    fin_nxt        = fin_r;
    last_nxt       = last_r;
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    sum_nxt        = sum_r;
    sq_nxt         = sq_r;
    nq_nxt         = nq_r;
    ss_nxt         = ss_r;
    lim2_nxt       = lim2_r;
    nn_nxt         = nn_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    lhs_nxt        = lhs_r;
    rhs_nxt        = rhs_r;
    ext_nxt        = ext_r;
    out_valid_nxt  = 1'b0;
    out_count_nxt  = out_count_r;
    out_frames_nxt = out_frames_r;

    if (cfg_valid) begin
      case (cfg_index)
        spc_pkg::REG_FRAME_PIXEL_COUNT: fpc_nxt    = cfg_data[spc_pkg::FPC_W-1:0];
        spc_pkg::REG_FLAT_LIMIT_Q4:     lim_nxt    = cfg_data[spc_pkg::LIM_W-1:0];
        spc_pkg::REG_EXTREME_MARGIN:    margin_nxt = cfg_data[spc_pkg::MARG_W-1:0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      pix_nxt  = in_pixel_value;
      pp_nxt   = spc_pkg::PP_W'(in_pixel_value) * spc_pkg::PP_W'(in_pixel_value);
      fin_nxt  = in_final_frame;
      last_nxt = last_now;
      addr_nxt = rd_addr;
      n_nxt    = fr_lt_max ? frame_r + spc_pkg::FN_W'(1)
                           : spc_pkg::FN_W'(spc_pkg::MAX_FRAMES);
    end

    if (cmd.acc) begin
      sum_nxt = acc_sum;
      sq_nxt  = acc_sq;
    end

    if (cmd.mul1) begin
      nq_nxt   = spc_pkg::NQ_W'(n_r) * spc_pkg::NQ_W'(sq_r);
      ss_nxt   = spc_pkg::SS_W'(sum_r) * spc_pkg::SS_W'(sum_r);
      lim2_nxt = spc_pkg::LIM2_W'(lim_r) * spc_pkg::LIM2_W'(lim_r);
      nn_nxt   = spc_pkg::NN_W'(n_r) * spc_pkg::NN_W'(n_r);
      lo_nxt   = spc_pkg::NM_W'(n_r) * spc_pkg::NM_W'(margin_r);
      hi_nxt   = spc_pkg::NM_W'(n_r) * spc_pkg::NM_W'(hi_margin);
    end

    if (cmd.mul2) begin
      lhs_nxt = {spread, {spc_pkg::FLAT_SHIFT{1'b0}}};
      rhs_nxt = spc_pkg::RHS_W'(lim2_r) * spc_pkg::RHS_W'(nn_r);
      ext_nxt = (spc_pkg::XW'(sum_r) < spc_pkg::XW'(lo_r)) ||
                (spc_pkg::XW'(sum_r) > spc_pkg::XW'(hi_r));
    end

    if (cmd.test) begin
      total_nxt = total_inc;
      if (last_r) begin
        pos_nxt = '0;
        if (!fin_r && fr_lt_max) begin
          frame_nxt = frame_r + spc_pkg::FN_W'(1);
        end
      end else begin
        pos_nxt = addr_r + spc_pkg::ADDR_W'(1);
      end
      if (cmd.emit) begin
        out_valid_nxt  = 1'b1;
        out_count_nxt  = total_inc;
        out_frames_nxt = spc_pkg::FU_W'(n_r);
        frame_nxt      = '0;
        total_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpc_r       <= spc_pkg::FPC_RESET;
      lim_r       <= spc_pkg::LIMIT_RESET;
      margin_r    <= spc_pkg::MARGIN_RESET;
      pos_r       <= '0;
      frame_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fpc_r       <= fpc_nxt;
      lim_r       <= lim_nxt;
      margin_r    <= margin_nxt;
      pos_r       <= pos_nxt;
      frame_r     <= frame_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r        <= pix_nxt;
    pp_r         <= pp_nxt;
    fin_r        <= fin_nxt;
    last_r       <= last_nxt;
    addr_r       <= addr_nxt;
    n_r          <= n_nxt;
    sum_r        <= sum_nxt;
    sq_r         <= sq_nxt;
    nq_r         <= nq_nxt;
    ss_r         <= ss_nxt;
    lim2_r       <= lim2_nxt;
    nn_r         <= nn_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    lhs_r        <= lhs_nxt;
    rhs_r        <= rhs_nxt;
    ext_r        <= ext_nxt;
    out_count_r  <= out_count_nxt;
    out_frames_r <= out_frames_nxt;
  end

  assign sts.last_px      = last_r;
  assign sts.final_px     = fin_r;
  assign out_valid        = out_valid_r;
  assign out_stuck_count  = out_count_r;
  assign out_frames_used  = out_frames_r;

  `SPC_ASSERT(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r)
  `SPC_ASSERT(a_emit_restarts, clk, rst_n, out_valid_r |-> (frame_r == '0 && total_r == '0 && pos_r == '0))
  `SPC_NEVER(a_frame_saturates, clk, rst_n, frame_r > spc_pkg::FN_W'(spc_pkg::MAX_FRAMES))

endmodule

### hdl/stuck_pixel_counter_core.sv
// top level of the stuck pixel counter: controller plus datapath
// depends on spc_pkg, spc_ctrl, spc_dp (which holds the spc_ram instances)
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  pixel in | start, busy            | in_pixel_value, in_final_frame
//  result   | out_valid (strobe)     | out_stuck_count, out_frames_used
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// each pixel request runs through ram read, accumulate and write back, two
// multiply steps, then the test; busy is high after accept until test is done
// the result strobe is high for one cycle right after the test of the last
// pixel of a final frame; the receiver cannot stall it; reset clears position,
// frame count and total and sets config to defaults; the stores are not
// cleared, the first frame overwrites them; config writes are always ready
module stuck_pixel_counter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [spc_pkg::PIX_W-1:0]      in_pixel_value,
  input  logic                           in_final_frame,
  output logic                           out_valid,
  output logic [spc_pkg::CNT_W-1:0]      out_stuck_count,
  output logic [spc_pkg::FU_W-1:0]       out_frames_used,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data
);

  spc_pkg::spc_cmd_t cmd;
  spc_pkg::spc_sts_t sts;

  assign cfg_ready = 1'b1;

  spc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  spc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .in_pixel_value  (in_pixel_value),
    .in_final_frame  (in_final_frame),
    .out_valid       (out_valid),
    .out_stuck_count (out_stuck_count),
    .out_frames_used (out_frames_used)
  );

endmodule

### sim/spc_result_checker.sv
// result checker for the stuck pixel counter: watches the pixel, config and result
// channels, predicts the stuck count of each sequence and compares it with the block
// depends on spc_pkg
module spc_result_checker
  import spc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic                  in_final_frame,
  input  logic                  out_valid,
  input  logic [CNT_W-1:0]      out_stuck_count,
  input  logic [FU_W-1:0]       out_frames_used,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    results_due
);

  typedef struct packed {
    logic [CNT_W-1:0] stuck_count;
    logic [FU_W-1:0]  frames_used;
  } count_result_t;

  count_result_t     counts_due [$];
  count_result_t     want;
  int unsigned       sum_mem [MAX_PIXELS];
  int unsigned       sq_mem [MAX_PIXELS];
  int unsigned       position;
  int unsigned       frame_no;
  logic [CNT_W-1:0]  stuck_total;
  logic [FPC_W-1:0]  frame_pixels;
  logic [LIM_W-1:0]  flat_limit;
  logic [MARG_W-1:0] margin;
  int                errors = 0;

  // exact integer form of "std dev below limit and mean near black or white"
  function automatic bit stuck_test(longint unsigned n, longint unsigned s,
                                    longint unsigned q);
    longint unsigned nq, ss, spread, lim, m;
    bit flat, extreme;
    nq      = n * q;
    ss      = s * s;
    spread  = (nq > ss) ? nq - ss : 64'd0;
    lim     = 64'(flat_limit);
    m       = 64'(margin);
    flat    = (spread << FLAT_SHIFT) < (lim * lim * n * n);
    extreme = (s < n * m) || (s > n * (GREY_MAX_I - m));
    return flat && extreme;
  endfunction

  task automatic take_pixel(logic [PIX_W-1:0] pix, logic fin);
    int unsigned fsize, pos, n, p;
    count_result_t due;
    p = 32'(pix);
    if (frame_pixels == 0) fsize = 1;
    else if (frame_pixels > MAX_PIXELS) fsize = MAX_PIXELS;
    else fsize = 32'(frame_pixels);
    pos = position;
    if (pos >= fsize) pos = fsize - 1;
    // first frame overwrites, frames past the maximum are dropped
    if (frame_no == 0) begin
      sum_mem[pos] = p;
      sq_mem[pos]  = p * p;
    end else if (frame_no < MAX_FRAMES) begin
      sum_mem[pos] += p;
      sq_mem[pos]  += p * p;
    end
    n = (frame_no < MAX_FRAMES) ? frame_no + 1 : MAX_FRAMES;
    if (fin && stuck_test(64'(n), 64'(sum_mem[pos]), 64'(sq_mem[pos])))
      stuck_total = stuck_total + 1'b1;
    if (pos + 1 >= fsize) begin
      position = 0;
      if (fin) begin
        due.stuck_count = stuck_total;
        due.frames_used = FU_W'(n);
        counts_due.insert(counts_due.size(), due);
        frame_no    = 0;
        stuck_total = '0;
      end else if (frame_no < MAX_FRAMES) begin
        frame_no++;
      end
    end else begin
      position = pos + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      position     = 0;
      frame_no     = 0;
      stuck_total  = '0;
      frame_pixels = FPC_RESET;
      flat_limit   = LIMIT_RESET;
      margin       = MARGIN_RESET;
      counts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_PIXEL_COUNT: frame_pixels = cfg_data[FPC_W-1:0];
          REG_FLAT_LIMIT_Q4:     flat_limit   = cfg_data[LIM_W-1:0];
          REG_EXTREME_MARGIN:    margin       = cfg_data[MARG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (counts_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request pending: stuck_count=%0d frames_used=%0d",
                     $time, out_stuck_count, out_frames_used);
        end else begin
          want = counts_due.pop_front();
          if (want.stuck_count !== out_stuck_count || want.frames_used !== out_frames_used) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected stuck_count=%0d frames_used=%0d, got %0d %0d",
                       $time, want.stuck_count, want.frames_used,
                       out_stuck_count, out_frames_used);
          end
        end
      end
      if (start && !busy) take_pixel(in_pixel_value, in_final_frame);
    end
    mismatch_count <= errors;
    results_due    <= counts_due.size();
  end

endmodule

### sim/stuck_pixel_counter_core_tb.sv
// testbench top for stuck_pixel_counter_core: clock, reset, pixel sequences and
// register writes, watchdog and verdict; checking lives in spc_result_checker
// depends on spc_pkg, spc_result_checker and the block itself
module stuck_pixel_counter_core_tb;
  import spc_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 480;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int SEQ_PIXELS    = 16;
  localparam int BIG_PIXELS    = 24;
  localparam int LIMIT_MAX     = (1 << LIM_W) - 1;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = 2'd3;
  localparam logic [CFG_DATA_W-1:0] BIG_FRAME = '1;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic [PIX_W-1:0]      in_pixel_value = '0;
  logic                  in_final_frame = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  busy;
  logic                  out_valid;
  logic [CNT_W-1:0]      out_stuck_count;
  logic [FU_W-1:0]       out_frames_used;
  logic                  cfg_ready;
  int                    mismatch_count;
  int                    results_due;

  int unsigned burst_left   = 0;
  int unsigned stall_cycles = 0;
  int unsigned random_items = 0;
  bit          gaps_on      = 1'b1;

  always #HALF_PERIOD clk = ~clk;

  stuck_pixel_counter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_value  (in_pixel_value),
    .in_final_frame  (in_final_frame),
    .out_valid       (out_valid),
    .out_stuck_count (out_stuck_count),
    .out_frames_used (out_frames_used),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  spc_result_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_value  (in_pixel_value),
    .in_final_frame  (in_final_frame),
    .out_valid       (out_valid),
    .out_stuck_count (out_stuck_count),
    .out_frames_used (out_frames_used),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due)
  );

  // any request, result or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // start stays high after an accept unless a gap follows, so back-to-back requests need no toggle
  task automatic send_pixel(logic [PIX_W-1:0] value, logic fin);
    start          <= 1'b1;
    in_pixel_value <= value;
    in_final_frame <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 30);
      end
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random bits above the register field, which the block must ignore
  function automatic logic [CFG_DATA_W-1:0] pad_word(int unsigned value, int w);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d = (d >> w) << w;
    return d | CFG_DATA_W'(value);
  endfunction

  function automatic logic [PIX_W-1:0] shade(int kind, int base);
    int v;
    case (kind)
      0:       v = base + $urandom_range(0, 3);
      1:       v = GREY_MAX_I - base - $urandom_range(0, 3);
      2:       v = $urandom_range(0, GREY_MAX_I);
      default: v = base;
    endcase
    return v[PIX_W-1:0];
  endfunction

  // frames of one sequence; the last pixel always closes it with the final flag
  task automatic run_sequence(int size, int frames);
    int   eff;
    int   kind [SEQ_PIXELS];
    int   base [SEQ_PIXELS];
    bit   noisy;
    logic fin;
    eff = (size == 0) ? 1 : size;
    for (int p = 0; p < eff; p++) begin
      kind[p] = $urandom_range(0, 3);
      base[p] = (kind[p] == 3) ? $urandom_range(0, GREY_MAX_I) : $urandom_range(0, 24);
    end
    for (int f = 0; f < frames; f++) begin
      noisy = ($urandom_range(0, 9) == 0);
      for (int p = 0; p < eff; p++) begin
        fin = (f == frames - 1);
        if (f == frames - 1 && p == eff - 1) fin = 1'b1;
        else if ($urandom_range(0, 19) == 0) fin = !fin;
        send_pixel(shade(noisy ? 2 : kind[p], base[p]), fin);
        random_items++;
      end
    end
    settle();
  endtask

  initial begin
    int seq_no;
    int size;
    int frames;
    int value;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero frame size acts as one pixel, widest limit and margin, spare index
    write_reg(REG_FRAME_PIXEL_COUNT, '0);
    write_reg(REG_FLAT_LIMIT_Q4, '1);
    write_reg(REG_EXTREME_MARGIN, '1);
    write_reg(REG_SPARE, 17'h0AAAA);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd254, 1'b1);
    settle();

    // zero limit and zero margin: nothing can be stuck
    write_reg(REG_FRAME_PIXEL_COUNT, 17'd2);
    write_reg(REG_FLAT_LIMIT_Q4, '0);
    write_reg(REG_EXTREME_MARGIN, '0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    settle();

    // final flag mid frame, then a frame that ends without the flag
    write_reg(REG_FRAME_PIXEL_COUNT, 17'd3);
    write_reg(REG_FLAT_LIMIT_Q4, 17'd16);
    write_reg(REG_EXTREME_MARGIN, 17'd10);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd101, 1'b1);
    settle();

    // margin at mid grey: the two bounds meet
    write_reg(REG_FRAME_PIXEL_COUNT, 17'd1);
    write_reg(REG_FLAT_LIMIT_Q4, 17'd4095);
    write_reg(REG_EXTREME_MARGIN, 17'd128);
    send_pixel(8'd127, 1'b1);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd56, 1'b1);
    settle();

    seq_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      // every eighth sequence runs up to or past the frame limit
      if (seq_no % 8 == 3) begin
        size   = $urandom_range(1, 2);
        frames = $urandom_range(MAX_FRAMES - 1, MAX_FRAMES + 4);
      end else begin
        size   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, SEQ_PIXELS);
        frames = $urandom_range(1, 6);
      end
      write_reg(REG_FRAME_PIXEL_COUNT, CFG_DATA_W'(size));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       value = 0;
          1:       value = LIMIT_MAX;
          2:       value = $urandom_range(1, 64);
          default: value = $urandom_range(0, LIMIT_MAX);
        endcase
        write_reg(REG_FLAT_LIMIT_Q4, pad_word(value, LIM_W));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       value = 0;
          1:       value = GREY_MAX_I;
          2:       value = 128;
          3, 4:    value = $urandom_range(1, 40);
          default: value = $urandom_range(0, GREY_MAX_I);
        endcase
        write_reg(REG_EXTREME_MARGIN, pad_word(value, MARG_W));
      end
      run_sequence(size, frames);
      seq_no++;
    end

    // oversized frame clamps to the full store; a short dark run never closes it
    write_reg(REG_FRAME_PIXEL_COUNT, BIG_FRAME);
    write_reg(REG_FLAT_LIMIT_Q4, pad_word($urandom_range(1, LIMIT_MAX), LIM_W));
    write_reg(REG_EXTREME_MARGIN, pad_word(10, MARG_W));
    gaps_on = 1'b0;
    for (int i = 0; i < BIG_PIXELS; i++) send_pixel(PIX_W'($urandom_range(0, 9)), 1'b1);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### stuck_pixel_counter_core.f
+incdir+hdl
hdl/spc_pkg.sv
hdl/spc_ram.sv
hdl/spc_ctrl.sv
hdl/spc_dp.sv
hdl/stuck_pixel_counter_core.sv
sim/spc_result_checker.sv
sim/stuck_pixel_counter_core_tb.sv
